// ----- design/stereo_sqrt_overdrive_lowpass_top_macros.svh -----
// ---------------------------------------------------------------------------
// stereo sqrt overdrive lowpass assertion macros
// shared concurrent assertion forms, compiled out when ASSERT_OFF is set
// ---------------------------------------------------------------------------
`ifndef STEREO_SQRT_OVERDRIVE_LOWPASS_TOP_MACROS_SVH
`define STEREO_SQRT_OVERDRIVE_LOWPASS_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define SQOD_ASSERT_IMP(lbl, c, r, ante, cons, msg) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define SQOD_ASSERT_NXT(lbl, c, r, ante, cons, msg) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) else $error(msg);
`else
`define SQOD_ASSERT_IMP(lbl, c, r, ante, cons, msg)
`define SQOD_ASSERT_NXT(lbl, c, r, ante, cons, msg)
`endif

`endif

// ----- design/sqod_pkg.sv -----
// ---------------------------------------------------------------------------
// sqod_pkg
// shared constants, types and helpers of the stereo sqrt overdrive lowpass
// ---------------------------------------------------------------------------
package sqod_pkg;

  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 16;
  localparam int GAIN_BITS          = 16;
  localparam int GAIN_FRAC_BITS     = 12;
  localparam int STATE_BITS         = 32;
  localparam int CFG_INDEX_W        = 2;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << GAIN_FRAC_BITS;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DRIVE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN  = 2'd2;

  typedef enum logic [1:0] {
    MUL_DRIVE_SEL,
    MUL_COEFF_SEL,
    MUL_GAIN_SEL
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     sq_init;
    logic     sq_step;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     blend_en;
    logic     filt_en;
    logic     out_en;
    logic     chan;
    logic     deliver;
  } cmd_t;

  typedef struct packed {
    logic sq_last;
  } status_t;

  // width of the config data port: widest register
  function automatic int cfg_width(input int coef_frac_bits);
    return (coef_frac_bits + 1 > GAIN_BITS) ? coef_frac_bits + 1 : GAIN_BITS;
  endfunction

endpackage

// ----- design/sqod_ctrl.sv -----
// ---------------------------------------------------------------------------
// sqod_ctrl
// sequencer: runs the square root, blend, filter and gain steps per channel
// ---------------------------------------------------------------------------
module sqod_ctrl
  import sqod_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    IDLE,
    SQ_INIT,
    SQ_STEP,
    MUL_DRIVE,
    BLEND,
    MUL_FILT,
    FILT,
    MUL_GAIN,
    RESULT,
    DELIVER
  } state_t;

  state_t state;
  logic   chan;
  logic   out_free;

  assign in_stall = (state != IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd      = '0;
    cmd.chan = chan;
    unique case (state)
      IDLE:      cmd.load_in  = in_valid;
      SQ_INIT:   cmd.sq_init  = 1'b1;
      SQ_STEP:   cmd.sq_step  = 1'b1;
      MUL_DRIVE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DRIVE_SEL;
      end
      BLEND:     cmd.blend_en = 1'b1;
      MUL_FILT:  begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_COEFF_SEL;
      end
      FILT:      cmd.filt_en  = 1'b1;
      MUL_GAIN:  begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GAIN_SEL;
      end
      RESULT:    cmd.out_en   = 1'b1;
      DELIVER:   cmd.deliver  = out_free;
      default:   cmd.chan     = chan;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      chan      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == DELIVER && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            chan  <= 1'b0;
            state <= SQ_INIT;
          end
        end
        SQ_INIT:   state <= SQ_STEP;
        SQ_STEP: begin
          if (status.sq_last) begin
            state <= MUL_DRIVE;
          end
        end
        MUL_DRIVE: state <= BLEND;
        BLEND:     state <= MUL_FILT;
        MUL_FILT:  state <= FILT;
        FILT:      state <= MUL_GAIN;
        MUL_GAIN:  state <= RESULT;
        RESULT: begin
          if (!chan) begin
            chan  <= 1'b1;
            state <= SQ_INIT;
          end else begin
            state <= DELIVER;
          end
        end
        DELIVER: begin
          // hold the pair until the output register is free
          if (out_free) begin
            state <= IDLE;
          end
        end
        default:   state <= IDLE;
      endcase
    end
  end

endmodule

// ----- design/sqod_datapath.sv -----
// ---------------------------------------------------------------------------
// sqod_datapath
// config registers, bit-serial square root, shared multiplier, filter state
// ---------------------------------------------------------------------------
module sqod_datapath
  import sqod_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wen,
  input  logic [CFG_INDEX_W-1:0]                cfg_index,
  input  logic [cfg_width(COEF_FRAC_BITS)-1:0]  cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]         left_sample,
  input  logic signed [SAMPLE_BITS-1:0]         right_sample,
  output logic signed [SAMPLE_BITS-1:0]         left_out,
  output logic signed [SAMPLE_BITS-1:0]         right_out,
  input  cmd_t                                  cmd,
  output status_t                               status
);

  localparam int SB    = SAMPLE_BITS;
  localparam int CF    = COEF_FRAC_BITS;
  localparam int CFG_W = cfg_width(COEF_FRAC_BITS);
  localparam int A_W   = ((SB + 2 > STATE_BITS) ? SB + 2 : STATE_BITS) + 1;
  localparam int B_W   = CFG_W + 1;
  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(SB + 1);

  localparam logic [CFG_W-1:0]      COEF_ONE = CFG_W'(1) << CF;
  localparam logic signed [P_W-1:0] HALF_CF  = P_W'(1) << (CF - 1);
  localparam logic signed [P_W-1:0] HALF_G   = P_W'(1) << (GAIN_FRAC_BITS - 1);

  // config registers
  logic [CF:0]           drive;
  logic [CF:0]           coeff;
  logic [GAIN_BITS-1:0]  gain;

  // sample and state registers
  logic signed [SB-1:0]          samp_l;
  logic signed [SB-1:0]          samp_r;
  logic signed [STATE_BITS-1:0]  st_l;
  logic signed [STATE_BITS-1:0]  st_r;
  logic signed [SB-1:0]          res_l;
  logic signed [SB-1:0]          res_r;

  // square root
  logic [2*SB-1:0]  sq_rad;
  logic [SB+1:0]    sq_rem;
  logic [SB-1:0]    sq_root;
  logic [CNT_W-1:0] sq_cnt;

  logic signed [P_W-1:0] prod;
  logic signed [SB+1:0]  blend;

  // combinational
  logic signed [SB-1:0]         x;
  logic signed [STATE_BITS-1:0] st_cur;
  logic [SB-1:0]                mag;
  logic                         x_pos;
  logic signed [SB:0]           root_s;
  logic signed [SB:0]           shaped;
  logic [SB+1:0]                rem_sh;
  logic [SB+1:0]                trial;
  logic                         ge;
  logic signed [A_W-1:0]        mul_a;
  logic signed [B_W-1:0]        mul_b;
  logic signed [P_W-1:0]        sh_cf;
  logic signed [P_W-1:0]        sh_g;
  logic signed [A_W:0]          st_sum;
  logic signed [STATE_BITS-1:0] st_new;
  logic [A_W-STATE_BITS+1:0]    st_top;
  logic [P_W-SB:0]              y_top;
  logic signed [SB-1:0]         y;

  assign x      = cmd.chan ? samp_r : samp_l;
  assign st_cur = cmd.chan ? st_r : st_l;
  assign mag    = x[SB-1] ? SB'(-x) : x;
  assign x_pos  = !x[SB-1] && (x != '0);
  assign root_s = {1'b0, sq_root};
  assign shaped = x_pos ? root_s : -root_s;

  // one root bit per step: bring down two radicand bits, try (root << 2) | 1
  assign rem_sh = {sq_rem[SB-1:0], sq_rad[2*SB-1 -: 2]};
  assign trial  = {sq_root, 2'b01};
  assign ge     = (rem_sh >= trial);

  assign status.sq_last = (sq_cnt == CNT_W'(1));

  always_comb begin
    case (cmd.mul_sel)
      MUL_DRIVE_SEL: begin
        mul_a = A_W'(shaped) - A_W'(x);
        mul_b = B_W'(drive);
      end
      MUL_COEFF_SEL: begin
        mul_a = A_W'(blend) - A_W'(st_cur);
        mul_b = B_W'(coeff);
      end
      MUL_GAIN_SEL: begin
        mul_a = A_W'(st_cur);
        mul_b = B_W'(gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // round half up, then floor by arithmetic shift
  assign sh_cf = (prod + HALF_CF) >>> CF;
  assign sh_g  = (prod + HALF_G) >>> GAIN_FRAC_BITS;

  // filter update with clamp to the 32-bit state range
  assign st_sum = (A_W + 1)'(st_cur) + (A_W + 1)'(sh_cf);
  assign st_top = st_sum[A_W:STATE_BITS-1];
  always_comb begin
    if ((&st_top) || !(|st_top)) begin
      st_new = st_sum[STATE_BITS-1:0];
    end else if (st_sum[A_W]) begin
      st_new = {1'b1, {(STATE_BITS-1){1'b0}}};
    end else begin
      st_new = {1'b0, {(STATE_BITS-1){1'b1}}};
    end
  end

  // output saturation
  assign y_top = sh_g[P_W-1:SB-1];
  always_comb begin
    if ((&y_top) || !(|y_top)) begin
      y = sh_g[SB-1:0];
    end else if (sh_g[P_W-1]) begin
      y = {1'b1, {(SB-1){1'b0}}};
    end else begin
      y = {1'b0, {(SB-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive <= '0;
      coeff <= COEF_ONE[CF:0];
      gain  <= GAIN_ONE;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_DRIVE: drive <= (cfg_data > COEF_ONE) ? COEF_ONE[CF:0] : cfg_data[CF:0];
        REG_COEFF: coeff <= (cfg_data > COEF_ONE) ? COEF_ONE[CF:0] : cfg_data[CF:0];
        REG_GAIN:  gain  <= cfg_data[GAIN_BITS-1:0];
        default:   gain  <= gain;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_l <= '0;
      st_r <= '0;
    end else if (cmd.filt_en) begin
      if (cmd.chan) begin
        st_r <= st_new;
      end else begin
        st_l <= st_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_cnt <= '0;
    end else if (cmd.sq_init) begin
      sq_cnt <= CNT_W'(SB);
    end else if (cmd.sq_step) begin
      sq_cnt <= sq_cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      samp_l <= left_sample;
      samp_r <= right_sample;
    end
    if (cmd.sq_init) begin
      sq_rad  <= {1'b0, mag, {(SB-1){1'b0}}};
      sq_rem  <= '0;
      sq_root <= '0;
    end else if (cmd.sq_step) begin
      sq_rad  <= sq_rad << 2;
      sq_rem  <= ge ? rem_sh - trial : rem_sh;
      sq_root <= {sq_root[SB-2:0], ge};
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.blend_en) begin
      blend <= (SB + 2)'(x) + (SB + 2)'(sh_cf);
    end
    if (cmd.out_en) begin
      if (cmd.chan) begin
        res_r <= y;
      end else begin
        res_l <= y;
      end
    end
    if (cmd.deliver) begin
      left_out  <= res_l;
      right_out <= res_r;
    end
  end

endmodule

// ----- design/stereo_sqrt_overdrive_lowpass_top.sv -----
// ---------------------------------------------------------------------------
// stereo_sqrt_overdrive_lowpass_top
// stereo square-root overdrive with per-channel one-pole lowpass and gain
// ---------------------------------------------------------------------------
// One sample pair is taken per transfer and gives one output pair. Each
// channel runs in turn through a bit-serial square root that yields one
// root bit per cycle, then three passes through one shared registered
// multiplier (drive blend, lowpass, output gain). The finished pair sits
// in an output register, so the next pair is taken as soon as the
// sequencer is back in idle, while the previous result may still wait.
// Config writes belong to idle periods; out-of-range drive or filter values
// are taken as 1.0, and writes to unknown indexes are dropped.
`include "stereo_sqrt_overdrive_lowpass_top_macros.svh"

module stereo_sqrt_overdrive_lowpass_top
  import sqod_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wen,
  input  logic [CFG_INDEX_W-1:0]                cfg_index,
  input  logic [cfg_width(COEF_FRAC_BITS)-1:0]  cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [SAMPLE_BITS-1:0]         left_sample,
  input  logic signed [SAMPLE_BITS-1:0]         right_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [SAMPLE_BITS-1:0]         left_out,
  output logic signed [SAMPLE_BITS-1:0]         right_out
);

  cmd_t    cmd;
  status_t status;

  sqod_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  sqod_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .left_out     (left_out),
    .right_out    (right_out),
    .cmd          (cmd),
    .status       (status)
  );

  // an accepted pair keeps the block busy for the next cycle
  `SQOD_ASSERT_NXT(a_busy_after_in, clk, rst, in_valid && !in_stall, in_stall, "not busy after input transfer")
  // a new result never overwrites one that is still waiting
  `SQOD_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.deliver, !(out_valid && out_stall), "result overwritten")
  `SQOD_ASSERT_NXT(a_deliver_valid, clk, rst, cmd.deliver, out_valid, "delivered result not valid")
  // datapath steps are mutually exclusive
  `SQOD_ASSERT_IMP(a_cmd_excl, clk, rst, 1'b1, $onehot0({cmd.load_in, cmd.sq_init, cmd.sq_step, cmd.mul_en, cmd.blend_en, cmd.filt_en, cmd.out_en, cmd.deliver}), "overlapping datapath commands")

endmodule

// ----- bench/tb.sv -----
// ---------------------------------------------------------------------------
// tb: stereo sqrt overdrive lowpass regression
// Drives stereo sample pairs over the valid/stall input channel and checks
// every output pair against a bit-exact model of the square-root blend,
// the one-pole lowpass and the saturating gain, kept in step per transfer.
// Directed extremes come first, then random traffic under several idle and
// stall mixes, then a long output hold-off that backs up the input.
// ---------------------------------------------------------------------------
module tb
  import sqod_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW    = SAMPLE_BITS_DEF;
  localparam int CFG_W = cfg_width(COEF_FRAC_BITS_DEF);
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  localparam longint COEF_ONE_Q = longint'(1) << COEF_FRAC_BITS_DEF;
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct packed {
    logic signed [SW-1:0] l_out;
    logic signed [SW-1:0] r_out;
  } out_pair_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_wen = 1'b0;
  logic [CFG_INDEX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]              cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [SW-1:0]          left_sample = '0;
  logic signed [SW-1:0]          right_sample = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SW-1:0]          left_out;
  logic signed [SW-1:0]          right_out;

  // predictor copy of the registers and the lowpass state
  longint drive_q;
  longint coeff_q;
  longint gain_q;
  longint left_lp_state;
  longint right_lp_state;

  out_pair_t pending_outputs[$];
  int        errors = 0;
  int        src_idle_pct = 0;
  int        sink_stall_pct = 0;
  int        hold_left = 0;

  stereo_sqrt_overdrive_lowpass_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .left_out     (left_out),
    .right_out    (right_out)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------- predictor ----------------

  function automatic longint round_q(input longint v, input int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 24; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic logic signed [SW-1:0] shape_channel(input logic signed [SW-1:0] x,
                                                         inout longint st);
    longint xs;
    longint mag;
    longint root;
    longint shaped;
    longint blend;
    longint y;
    xs = longint'(x);
    mag = (xs < 0) ? -xs : xs;
    root = longint'(int_sqrt(longint'(mag << (SW - 1))));
    // zero and negative samples take the negated root
    shaped = (xs > 0) ? root : -root;
    blend = xs + round_q((shaped - xs) * drive_q, COEF_FRAC_BITS_DEF);
    st = st + round_q((blend - st) * coeff_q, COEF_FRAC_BITS_DEF);
    if (st > 64'sd2147483647) st = 64'sd2147483647;
    if (st < -64'sd2147483648) st = -64'sd2147483648;
    y = round_q(st * gain_q, GAIN_FRAC_BITS);
    if (y > longint'(S_MAX)) y = longint'(S_MAX);
    if (y < longint'(S_MIN)) y = longint'(S_MIN);
    return y[SW-1:0];
  endfunction

  // ---------------- shared tasks ----------------

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  task automatic send_pair(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r);
    out_pair_t want;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    left_sample  <= l;
    right_sample <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer taken at this edge
    want.l_out = shape_channel(l, left_lp_state);
    want.r_out = shape_channel(r, right_lp_state);
    pending_outputs.push_back(want);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DRIVE: drive_q = (longint'(value) > COEF_ONE_Q) ? COEF_ONE_Q : longint'(value);
      REG_COEFF: coeff_q = (longint'(value) > COEF_ONE_Q) ? COEF_ONE_Q : longint'(value);
      REG_GAIN:  gain_q  = longint'(value[GAIN_BITS-1:0]);
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [CFG_W-1:0] drive, input logic [CFG_W-1:0] coeff,
                          input logic [CFG_W-1:0] gain);
    wait_idle();
    write_reg(REG_DRIVE, drive);
    write_reg(REG_COEFF, coeff);
    write_reg(REG_GAIN, gain);
  endtask

  function automatic logic signed [SW-1:0] pick_sample();
    logic signed [SW-1:0] s;
    case ($urandom_range(0, 9)) inside
      [0:4]: s = SW'($urandom);
      [5:6]: begin
        s = SW'($urandom_range(0, 255));
        if ($urandom_range(0, 1) != 0) s = -s;
      end
      7: begin
        case ($urandom_range(0, 4))
          0:       s = S_MAX;
          1:       s = S_MIN;
          2:       s = '0;
          3:       s = SW'(1);
          default: s = -SW'(1);
        endcase
      end
      default: begin
        s = SW'($urandom_range(0, 65536));
        if ($urandom_range(0, 1) != 0) s = -s;
      end
    endcase
    return s;
  endfunction

  function automatic logic [CFG_W-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_W'(COEF_ONE_Q);
      2:       return CFG_W'($urandom_range(COEF_ONE_Q + 1, (1 << CFG_W) - 1));
      default: return CFG_W'($urandom_range(0, COEF_ONE_Q));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_W'(16'hFFFF);
      2:       return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(1024, 16384));
    endcase
  endfunction

  // ---------------- receiver and checker ----------------

  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    out_pair_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch("output transfer with nothing pending");
      end else begin
        want = pending_outputs.pop_front();
        if (left_out !== want.l_out)
          report_mismatch($sformatf("left_out got %0d want %0d", left_out, want.l_out));
        if (right_out !== want.r_out)
          report_mismatch($sformatf("right_out got %0d want %0d", right_out, want.r_out));
      end
    end
  end

  // ---------------- tests ----------------

  task automatic test_reset_defaults();
    // reset values pass the sample straight through
    send_pair('0, '0);
    send_pair(S_MAX, S_MIN);
    send_pair(SW'(1), -SW'(1));
    send_pair(-SW'(1), SW'(1));
    send_pair(SW'($urandom), SW'($urandom));
  endtask

  task automatic test_directed_cases();
    // full square-root shaping, no filtering, unity gain
    set_regs(CFG_W'(COEF_ONE_Q), CFG_W'(COEF_ONE_Q), CFG_W'(GAIN_ONE));
    send_pair(S_MIN, S_MAX);
    send_pair(SW'(1), -SW'(1));
    send_pair('0, SW'(2));
    send_pair(SW'(4), -SW'(4));
    // values above one clamp, gain keeps its low bits only
    set_regs({CFG_W{1'b1}}, CFG_W'(100000), CFG_W'(17'h1F000));
    send_pair(S_MAX, S_MIN);
    send_pair(S_MIN, S_MAX);
    // unknown index must leave everything alone
    wait_idle();
    write_reg(REG_UNUSED, {CFG_W{1'b1}});
    send_pair(24'sh123456, -24'sh123456);
    // zero coefficient freezes the lowpass state
    set_regs(CFG_W'(32768), '0, CFG_W'(GAIN_ONE));
    send_pair(S_MAX, S_MIN);
    send_pair(S_MIN, S_MAX);
    // tiny state, no flush to zero, max gain
    set_regs('0, CFG_W'(1), CFG_W'(16'hFFFF));
    send_pair(SW'(3), -SW'(3));
    send_pair('0, '0);
    send_pair(S_MAX, S_MIN);
    // zero gain
    set_regs(CFG_W'(COEF_ONE_Q), CFG_W'(COEF_ONE_Q), '0);
    send_pair(S_MAX, S_MIN);
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 45; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 45; end
        default: begin src_idle_pct = 21; sink_stall_pct = 21; end
      endcase
      for (int k = 0; k < 5; k++) begin
        set_regs(pick_coef(), pick_coef(), pick_gain());
        for (int n = 0; n < 53; n++) send_pair(pick_sample(), pick_sample());
      end
    end
  endtask

  task automatic test_input_backpressure();
    set_regs(CFG_W'($urandom_range(0, COEF_ONE_Q)), CFG_W'($urandom_range(1, COEF_ONE_Q)),
             CFG_W'(GAIN_ONE));
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    // long output hold-off while inputs keep coming
    hold_left = 400;
    for (int n = 0; n < 12; n++) send_pair(pick_sample(), pick_sample());
  endtask

  initial begin
    drive_q        = 0;
    coeff_q        = COEF_ONE_Q;
    gain_q         = longint'(GAIN_ONE);
    left_lp_state  = 0;
    right_lp_state = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_cases();
    test_random_phases();
    test_input_backpressure();
    wait_idle();
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
